// ===== design/ptc_pkg.sv =====
// ptc_pkg: widths, limits and register codes for the pressure and temperature
// compensation pipeline. No dependencies; used by the interfaces and the top level.
`default_nettype none

package ptc_pkg;

	localparam int RAW_W      = 24;
	localparam int CAL_W      = 16;
	localparam int ADDR_W     = 3;
	localparam int TEMP_W     = 15;
	localparam int PRES_W     = 17;
	localparam int CAL_COUNT  = 6;
	localparam int NUM_STAGES = 9;

	localparam int TEMP_BASE = 2000;
	localparam int TEMP_KNEE = -1500;
	localparam int TEMP_MIN  = -4000;
	localparam int TEMP_MAX  = 8500;
	localparam int PRES_MIN  = 1000;
	localparam int PRES_MAX  = 120000;

	typedef enum logic [ADDR_W-1:0] {
		CAL_SENS     = 3'd0,
		CAL_OFF      = 3'd1,
		CAL_TCS      = 3'd2,
		CAL_TCO      = 3'd3,
		CAL_TREF     = 3'd4,
		CAL_TEMPSENS = 3'd5
	} cal_reg_t;

endpackage

`default_nettype wire

// ===== design/ptc_ifs.sv =====
// ptc_ifs: handshake channels for the compensation block (sample, result, config).
// Depends on ptc_pkg.
`default_nettype none

interface ptc_sample_if import ptc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_pressure;
	logic [RAW_W-1:0]  raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_result_if import ptc_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [PRES_W-1:0]        pressure_pa;

	modport source (output valid, output temperature_centi, output pressure_pa, input ready);
	modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

interface ptc_cfg_if import ptc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] addr;
	logic [CAL_W-1:0]  data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pressure_temperature_compensation.sv =====
// pressure_temperature_compensation: second-order barometric compensation pipeline.
// Depends on ptc_pkg and the channel interfaces in ptc_ifs.
// Each accepted sample word passes through the registered stages s1 to s9 to its result word.
// Throughput: one word per cycle; each stage holds one word and moves up when the
// stage ahead is empty or moving, so a stalled result fills the pipeline first.
// Reset clears all stage valid bits and the six calibration words to zero.
`default_nettype none

module pressure_temperature_compensation import ptc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ptc_cfg_if.sink       cfg,
	ptc_sample_if.sink    sample,
	ptc_result_if.source  result
);

	logic [CAL_W-1:0]      cal_q [CAL_COUNT];
	logic [NUM_STAGES:1]   stage_valid_q;
	logic [NUM_STAGES:1]   stage_en;

	// stage 1
	logic signed [24:0]    dt_s1;
	logic [RAW_W-1:0]      d1_s1;
	// stage 2
	logic signed [41:0]    t_prod_s2, off_prod_s2, sens_prod_s2;
	logic signed [49:0]    dd_s2;
	logic [RAW_W-1:0]      d1_s2;
	// stage 3
	logic signed [18:0]    dtemp_s3;
	logic signed [19:0]    temp_s3, tp_s3;
	logic signed [41:0]    off1_s3;
	logic signed [39:0]    sens1_s3;
	logic [17:0]           t2_s3;
	logic                  cold_s3, low_knee_s3;
	logic [RAW_W-1:0]      d1_s3;
	// stage 4
	logic [35:0]           sq1_s4, sq2_s4;
	logic signed [19:0]    temp_s4;
	logic signed [41:0]    off1_s4;
	logic signed [39:0]    sens1_s4;
	logic [17:0]           t2_s4;
	logic                  cold_s4, low_knee_s4;
	logic [RAW_W-1:0]      d1_s4;
	// stage 5
	logic [39:0]           off2_s5, sens2_s5;
	logic signed [19:0]    temp_s5;
	logic signed [41:0]    off1_s5;
	logic signed [39:0]    sens1_s5;
	logic [RAW_W-1:0]      d1_s5;
	// stage 6
	logic signed [41:0]    off_s6;
	logic signed [39:0]    sens_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic [RAW_W-1:0]      d1_s6;
	// stage 7
	logic [43:0]           pl_s7;
	logic signed [44:0]    ph_s7;
	logic signed [41:0]    off_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	// stage 8
	logic signed [65:0]    prod_s8;
	logic signed [41:0]    off_s8;
	logic signed [TEMP_W-1:0] temp_s8;
	// stage 9
	logic [PRES_W-1:0]     pres_s9;
	logic signed [TEMP_W-1:0] temp_s9;

	// combinational helpers
	logic signed [18:0]    dtemp_c;
	logic signed [19:0]    tp_c;
	logic signed [34:0]    off_sh_c;
	logic signed [33:0]    sens_sh_c;
	logic signed [37:0]    sq1_c;
	logic signed [39:0]    sq2_c;
	logic [38:0]           five_sq_c, sev_sq_c;
	logic [39:0]           elev_sq_c, off2_c, sens2_c;
	logic signed [45:0]    x_c;
	logic signed [30:0]    pres_c;

	// calibration words
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_COUNT; i++) cal_q[i] <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.addr)
				CAL_SENS:     cal_q[CAL_SENS]     <= cfg.data;
				CAL_OFF:      cal_q[CAL_OFF]      <= cfg.data;
				CAL_TCS:      cal_q[CAL_TCS]      <= cfg.data;
				CAL_TCO:      cal_q[CAL_TCO]      <= cfg.data;
				CAL_TREF:     cal_q[CAL_TREF]     <= cfg.data;
				CAL_TEMPSENS: cal_q[CAL_TEMPSENS] <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	always_comb begin
		stage_en[NUM_STAGES] = !stage_valid_q[NUM_STAGES] || result.ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--)
			stage_en[i] = !stage_valid_q[i] || stage_en[i+1];
	end

	assign sample.ready = stage_en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (stage_en[1]) stage_valid_q[1] <= sample.valid;
			for (int i = 2; i <= NUM_STAGES; i++)
				if (stage_en[i]) stage_valid_q[i] <= stage_valid_q[i-1];
		end
	end

	// s1: dT
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			dt_s1 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, cal_q[CAL_TREF], 8'h00});
			d1_s1 <= sample.raw_pressure;
		end
	end

	// s2: products with dT
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			t_prod_s2    <= dt_s1 * $signed({1'b0, cal_q[CAL_TEMPSENS]});
			off_prod_s2  <= dt_s1 * $signed({1'b0, cal_q[CAL_TCO]});
			sens_prod_s2 <= dt_s1 * $signed({1'b0, cal_q[CAL_TCS]});
			dd_s2        <= dt_s1 * dt_s1;
			d1_s2        <= d1_s1;
		end
	end

	// s3: first-order TEMP, OFF, SENS
	assign dtemp_c   = t_prod_s2[41:23];
	assign tp_c      = 20'(dtemp_c) + 20'(TEMP_BASE - TEMP_KNEE);
	assign off_sh_c  = off_prod_s2[41:7];
	assign sens_sh_c = sens_prod_s2[41:8];

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			dtemp_s3    <= dtemp_c;
			temp_s3     <= 20'(dtemp_c) + 20'(TEMP_BASE);
			tp_s3       <= tp_c;
			off1_s3     <= $signed({10'b0, cal_q[CAL_OFF], 16'b0}) + 42'(off_sh_c);
			sens1_s3    <= $signed({9'b0, cal_q[CAL_SENS], 15'b0}) + 40'(sens_sh_c);
			t2_s3       <= dd_s2[48:31];
			cold_s3     <= dtemp_c[18];
			low_knee_s3 <= tp_c[19];
			d1_s3       <= d1_s2;
		end
	end

	// s4: squares of the temperature deltas
	assign sq1_c = dtemp_s3 * dtemp_s3;
	assign sq2_c = tp_s3 * tp_s3;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			sq1_s4      <= sq1_c[35:0];
			sq2_s4      <= sq2_c[35:0];
			temp_s4     <= temp_s3;
			off1_s4     <= off1_s3;
			sens1_s4    <= sens1_s3;
			t2_s4       <= t2_s3;
			cold_s4     <= cold_s3;
			low_knee_s4 <= low_knee_s3;
			d1_s4       <= d1_s3;
		end
	end

	// s5: second-order terms
	assign five_sq_c = {1'b0, sq1_s4, 2'b0} + {3'b0, sq1_s4};
	assign sev_sq_c  = {sq2_s4, 3'b0} - {3'b0, sq2_s4};
	assign elev_sq_c = {1'b0, sq2_s4, 3'b0} + {3'b0, sq2_s4, 1'b0} + {4'b0, sq2_s4};
	assign off2_c    = {2'b0, five_sq_c[38:1]} + (low_knee_s4 ? {1'b0, sev_sq_c} : 40'b0);
	assign sens2_c   = {3'b0, five_sq_c[38:2]} + (low_knee_s4 ? {1'b0, elev_sq_c[39:1]} : 40'b0);

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			off2_s5  <= cold_s4 ? off2_c : 40'b0;
			sens2_s5 <= cold_s4 ? sens2_c : 40'b0;
			temp_s5  <= temp_s4 - (cold_s4 ? $signed({2'b0, t2_s4}) : 20'sd0);
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			d1_s5    <= d1_s4;
		end
	end

	// s6: corrected OFF and SENS, temperature clamp
	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			off_s6  <= off1_s5 - $signed({2'b0, off2_s5});
			sens_s6 <= sens1_s5 - $signed({1'b0, sens2_s5[38:0]});
			if (temp_s5 < 20'(TEMP_MIN))
				temp_s6 <= TEMP_W'(TEMP_MIN);
			else if (temp_s5 > 20'(TEMP_MAX))
				temp_s6 <= TEMP_W'(TEMP_MAX);
			else
				temp_s6 <= temp_s5[TEMP_W-1:0];
			d1_s6 <= d1_s5;
		end
	end

	// s7: D1 * SENS as two partial products
	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			pl_s7   <= d1_s6 * sens_s6[19:0];
			ph_s7   <= $signed({1'b0, d1_s6}) * $signed(sens_s6[39:20]);
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	// s8: sum of partial products
	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			prod_s8 <= (66'(ph_s7) <<< 20) + $signed({22'b0, pl_s7});
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
		end
	end

	// s9: pressure and clamp
	assign x_c    = 46'($signed(prod_s8[65:21])) - 46'(off_s8);
	assign pres_c = x_c[45:15];

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			if (pres_c < 31'(PRES_MIN))
				pres_s9 <= PRES_W'(PRES_MIN);
			else if (pres_c > 31'(PRES_MAX))
				pres_s9 <= PRES_W'(PRES_MAX);
			else
				pres_s9 <= pres_c[PRES_W-1:0];
			temp_s9 <= temp_s8;
		end
	end

	assign result.valid             = stage_valid_q[NUM_STAGES];
	assign result.temperature_centi = temp_s9;
	assign result.pressure_pa       = pres_s9;

	// checks
	a_blocked_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&stage_valid_q))
		else $error("input blocked with a bubble in the pipeline");

	a_knee_is_cold: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_valid_q[3] && low_knee_s3) |-> cold_s3)
		else $error("low temperature flag without cold flag");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.temperature_centi >= TEMP_W'(TEMP_MIN)
		&& result.temperature_centi <= TEMP_W'(TEMP_MAX)))
		else $error("temperature word out of range");

	a_pres_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pressure_pa >= PRES_W'(PRES_MIN)
		&& result.pressure_pa <= PRES_W'(PRES_MAX)))
		else $error("pressure word out of range");

endmodule

`default_nettype wire
